// ===== rtl/cfts_pkg.sv =====
package cfts_pkg;

	localparam int NUM_CSRS      = 32;
	localparam int XLEN          = 64;
	localparam int COUNT_INDEX   = 6;
	localparam int COMPARE_INDEX = 7;
	localparam int CYCLE_INDEX   = 16;
	localparam int STATUS_INDEX  = 10;

	localparam int EPC_WORD   = 2;
	localparam int EVEC_WORD  = 8;
	localparam int CAUSE_WORD = 9;

	localparam int ST_S   = 0;
	localparam int ST_PS  = 1;
	localparam int ST_EI  = 2;
	localparam int ST_PEI = 3;

	localparam int PORT_W  = 64;
	localparam int OP_W    = 3;
	localparam int IDX_W   = 5;
	localparam int CAUSE_W = 5;
	localparam int COUNT_W = 32;
	localparam int CYCLE_W = 64;

	localparam logic [CAUSE_W-1:0] CAUSE_RESET = 5'd6;

	typedef enum logic [OP_W-1:0] {
		OP_RW    = 3'd0,
		OP_RS    = 3'd1,
		OP_RC    = 3'd2,
		OP_SRET  = 3'd3,
		OP_SCALL = 3'd4,
		OP_TICK  = 3'd5
	} op_t;

	typedef logic [XLEN-1:0] word_t;
	typedef word_t store_t [NUM_CSRS];

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  csr_index;
		logic [PORT_W-1:0] write_value;
		logic [PORT_W-1:0] trap_pc;
	} item_t;

endpackage

// ===== rtl/csr_file_with_trap_stack_core.sv =====
// channel  | handshake                    | payload
// item     | item_valid / item_stall      | op, csr_index, write_value, trap_pc
// result   | result_valid / result_stall  | read_value
// config   | cfg_we                       | cfg_wdata (system call cause)
//
// an item is registered on entry and its result in the result register, and
// one item is taken every cycle unless a held result stalls the entry stage
// the control-register read-modify-write sits between the entry register
// and the result register, state updates as the result is registered
// reset clears every control register, both timers and the cause to six
// item_stall rises only while a result is held and the entry stage is full
module csr_file_with_trap_stack_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [cfts_pkg::OP_W-1:0]     op,
	input  logic [cfts_pkg::IDX_W-1:0]    csr_index,
	input  logic [cfts_pkg::PORT_W-1:0]   write_value,
	input  logic [cfts_pkg::PORT_W-1:0]   trap_pc,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [cfts_pkg::PORT_W-1:0]   read_value,
	input  logic                          cfg_we,
	input  logic [cfts_pkg::CAUSE_W-1:0]  cfg_wdata
);
	import cfts_pkg::*;

	item_t                item_s1;
	logic                 valid_s1;
	logic                 valid_q;
	logic [PORT_W-1:0]    read_value_q;
	logic [CAUSE_W-1:0]   cause_q;
	logic [PORT_W-1:0]    result;
	logic                 out_free;
	logic                 fire;

	assign out_free   = !valid_q || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cause_q <= CAUSE_RESET;
		end else if (cfg_we) begin
			cause_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{op: op, csr_index: csr_index, write_value: write_value,
				trap_pc: trap_pc};
		end
		if (fire) begin
			read_value_q <= result;
		end
	end

	cfts_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.scall_cause (cause_q),
		.result      (result)
	);

	assign result_valid = valid_q;
	assign read_value   = read_value_q;

endmodule

// ===== rtl/cfts_exec.sv =====
module cfts_exec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  cfts_pkg::item_t               item,
	input  logic [cfts_pkg::CAUSE_W-1:0]  scall_cause,
	output logic [cfts_pkg::PORT_W-1:0]   result
);
	import cfts_pkg::*;

	store_t               csr_q;
	store_t               csr_d;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   count_d;
	logic [CYCLE_W-1:0]   cycle_q;
	logic [CYCLE_W-1:0]   cycle_d;

	word_t                src;
	word_t                pc;
	word_t                res;
	word_t                old;
	word_t                merged;
	word_t                st;
	logic [IDX_W-1:0]     idx;

	always_comb begin
		src     = item.write_value[XLEN-1:0];
		pc      = item.trap_pc[XLEN-1:0];
		idx     = item.csr_index;
		csr_d   = csr_q;
		count_d = count_q;
		cycle_d = cycle_q;
		res     = '0;
		old     = '0;
		merged  = '0;
		st      = '0;
		unique case (op_t'(item.op))
			OP_RW, OP_RS, OP_RC: begin
				if (idx == IDX_W'(COUNT_INDEX)) begin
					old = XLEN'(count_q);
				end else if (idx == IDX_W'(CYCLE_INDEX) && idx != IDX_W'(COMPARE_INDEX)) begin
					old = cycle_q[XLEN-1:0];
				end else begin
					old = csr_q[idx];
				end
				unique case (op_t'(item.op))
					OP_RW:   merged = src;
					OP_RS:   merged = old | src;
					default: merged = old & ~src;
				endcase
				res = old;
				if (idx == IDX_W'(COUNT_INDEX)) begin
					count_d = merged[COUNT_W-1:0];
				end else if (idx == IDX_W'(COMPARE_INDEX)) begin
					csr_d[idx] = XLEN'(merged[COUNT_W-1:0]);
				end else if (idx != IDX_W'(CYCLE_INDEX)) begin
					csr_d[idx] = merged;
				end
			end
			OP_SRET: begin
				st                  = csr_q[STATUS_INDEX];
				st[ST_S]            = st[ST_PS];
				st[ST_EI]           = st[ST_PEI];
				csr_d[STATUS_INDEX] = st;
				res                 = csr_d[EPC_WORD];
			end
			OP_SCALL: begin
				csr_d[CAUSE_WORD]   = XLEN'(scall_cause);
				st                  = csr_d[STATUS_INDEX];
				st[ST_PS]           = st[ST_S];
				st[ST_S]            = 1'b1;
				st[ST_PEI]          = st[ST_EI];
				st[ST_EI]           = 1'b0;
				csr_d[STATUS_INDEX] = st;
				csr_d[EPC_WORD]     = pc;
				res                 = csr_d[EVEC_WORD];
			end
			OP_TICK: begin
				cycle_d = cycle_q + CYCLE_W'(1);
				count_d = count_q + COUNT_W'(1);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign result = PORT_W'(res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csr_q   <= '{default: '0};
			count_q <= '0;
			cycle_q <= '0;
		end else if (fire) begin
			csr_q   <= csr_d;
			count_q <= count_d;
			cycle_q <= cycle_d;
		end
	end

endmodule

// ===== rtl/cfts_checker.sv =====
module cfts_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [cfts_pkg::PORT_W-1:0]   read_value
);

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(read_value))
		else $error("held result changed");

	// entry stage backs up only behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without a held result");

	// an accepted item shows up as a result after the entry and result registers or waits behind one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> ##1 result_valid)
		else $error("accepted item produced no result");

endmodule

bind csr_file_with_trap_stack_core cfts_checker u_cfts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.read_value   (read_value)
);

// ===== sim/csr_file_with_trap_stack_core_test.sv =====
module csr_file_with_trap_stack_core_test;
	import cfts_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 260;
	localparam word_t ONES = '1;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		word_t            wv;
		word_t            pc;
		bit               fixed;
		word_t            want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [OP_W-1:0]     op = '0;
	logic [IDX_W-1:0]    csr_index = '0;
	word_t               write_value = '0;
	word_t               trap_pc = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	word_t               read_value;
	logic                cfg_we = 1'b0;
	logic [CAUSE_W-1:0]  cfg_wdata = '0;

	// expectation source for the item on the port
	logic                row_fixed = 1'b0;
	word_t               row_want = '0;

	word_t               model_csr [NUM_CSRS];
	logic [COUNT_W-1:0]  model_count;
	logic [CYCLE_W-1:0]  model_cycle;
	logic [CAUSE_W-1:0]  model_cause;

	word_t               expected_reads [$];
	int                  errors = 0;
	int                  cycles = 0;
	int                  stall_left = 0;
	bit                  quiet = 1'b0;
	word_t               predicted;

	logic [IDX_W-1:0] hot_idx [8] = '{
		IDX_W'(COUNT_INDEX), IDX_W'(COMPARE_INDEX), IDX_W'(CYCLE_INDEX),
		IDX_W'(STATUS_INDEX), IDX_W'(EPC_WORD), IDX_W'(EVEC_WORD),
		IDX_W'(CAUSE_WORD), 5'd31
	};

	row_t plan [25] = '{
		'{OP_RW,    5'd0,                ONES, '0, 1'b1, '0},
		'{OP_RS,    5'd0,                '0,   '0, 1'b1, ONES},
		'{OP_RC,    5'd0,                ONES, '0, 1'b1, ONES},
		'{OP_RW,    5'd31,               64'h8000_0000_0000_0001, '0, 1'b1, '0},
		'{OP_RS,    5'd31,               '0,   '0, 1'b1, 64'h8000_0000_0000_0001},
		'{OP_RW,    IDX_W'(COUNT_INDEX),   ONES, '0, 1'b1, '0},
		'{OP_RS,    IDX_W'(COUNT_INDEX),   '0,   '0, 1'b1, 64'h0000_0000_ffff_ffff},
		'{OP_TICK,  5'd0,                ONES, ONES, 1'b1, '0},
		'{OP_RC,    IDX_W'(COUNT_INDEX),   '0,   '0, 1'b1, '0},
		'{OP_RW,    IDX_W'(COMPARE_INDEX), ONES, '0, 1'b1, '0},
		'{OP_RS,    IDX_W'(COMPARE_INDEX), '0,   '0, 1'b1, 64'h0000_0000_ffff_ffff},
		'{OP_RW,    IDX_W'(CYCLE_INDEX),   ONES, '0, 1'b1, 64'd1},
		'{OP_RS,    IDX_W'(CYCLE_INDEX),   '0,   '0, 1'b1, 64'd1},
		'{OP_RC,    IDX_W'(CYCLE_INDEX),   ONES, '0, 1'b1, 64'd1},
		'{OP_RW,    IDX_W'(EVEC_WORD),     64'h0000_0000_8000_0100, '0, 1'b1, '0},
		'{OP_RW,    IDX_W'(STATUS_INDEX),  64'h0000_0000_0000_0004, '0, 1'b1, '0},
		'{OP_SCALL, 5'd0,                '0,   ONES, 1'b1, 64'h0000_0000_8000_0100},
		'{OP_RS,    IDX_W'(CAUSE_WORD),    '0,   '0, 1'b1, 64'd6},
		'{OP_RS,    IDX_W'(STATUS_INDEX),  '0,   '0, 1'b0, '0},
		'{OP_SCALL, 5'd0,                '0,   64'h1234_5678_9abc_def0, 1'b0, '0},
		'{OP_SRET,  5'd0,                '0,   '0, 1'b0, '0},
		'{OP_RS,    IDX_W'(EPC_WORD),      '0,   '0, 1'b0, '0},
		'{OP_SRET,  5'd0,                '0,   '0, 1'b0, '0},
		'{OP_SPARE6, 5'd31,              ONES, ONES, 1'b1, '0},
		'{OP_SPARE7, 5'd0,               ONES, ONES, 1'b1, '0}
	};

	csr_file_with_trap_stack_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.csr_index    (csr_index),
		.write_value  (write_value),
		.trap_pc      (trap_pc),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_value   (read_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic word_t merge_word(input logic [OP_W-1:0] kind, input word_t old,
		input word_t src);
		if (kind == OP_RW)
			return src;
		if (kind == OP_RS)
			return old | src;
		return old & ~src;
	endfunction

	function automatic word_t csr_apply(input logic [OP_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input word_t src, input word_t pc);
		word_t old;
		word_t st;
		old = '0;
		case (kind)
			OP_RW, OP_RS, OP_RC: begin
				if (idx == IDX_W'(COUNT_INDEX)) begin
					old = {32'b0, model_count};
					st = merge_word(kind, old, src);
					model_count = st[COUNT_W-1:0];
				end else if (idx == IDX_W'(COMPARE_INDEX)) begin
					old = model_csr[idx];
					model_csr[idx] = merge_word(kind, old, src) & 64'h0000_0000_ffff_ffff;
				end else if (idx == IDX_W'(CYCLE_INDEX)) begin
					old = model_cycle;
				end else begin
					old = model_csr[idx];
					model_csr[idx] = merge_word(kind, old, src);
				end
			end
			OP_SRET: begin
				st = model_csr[STATUS_INDEX];
				st[ST_S] = st[ST_PS];
				st[ST_EI] = st[ST_PEI];
				model_csr[STATUS_INDEX] = st;
				old = model_csr[EPC_WORD];
			end
			OP_SCALL: begin
				model_csr[CAUSE_WORD] = {{(XLEN-CAUSE_W){1'b0}}, model_cause};
				st = model_csr[STATUS_INDEX];
				st[ST_PS] = st[ST_S];
				st[ST_S] = 1'b1;
				st[ST_PEI] = st[ST_EI];
				st[ST_EI] = 1'b0;
				model_csr[STATUS_INDEX] = st;
				model_csr[EPC_WORD] = pc;
				old = model_csr[EVEC_WORD];
			end
			OP_TICK: begin
				model_cycle = model_cycle + CYCLE_W'(1);
				model_count = model_count + COUNT_W'(1);
			end
			default: old = '0;
		endcase
		return old;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report(input string what, input word_t got, input word_t want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result side: compare and draw the stall for the next result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (result_valid && !result_stall) begin
			if (expected_reads.size() == 0)
				report("unexpected read_value", read_value, '0);
			else if (read_value !== expected_reads[0])
				report("read_value", read_value, expected_reads.pop_front());
			else
				void'(expected_reads.pop_front());
			stall_left = quiet ? 0 : $urandom_range(0, 4);
			if (stall_left > 0)
				result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				result_stall <= 1'b0;
		end
		if (arst_n && item_valid && !item_stall) begin
			predicted = csr_apply(op, csr_index, write_value, trap_pc);
			expected_reads.push_back(row_fixed ? row_want : predicted);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("csr_file_with_trap_stack_core_test: errors");
			$finish;
		end
	end

	task automatic drive_item(input logic [OP_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input word_t wv, input word_t pc, input bit fixed, input word_t want);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= kind;
		csr_index <= idx;
		write_value <= wv;
		trap_pc <= pc;
		row_fixed <= fixed;
		row_want <= want;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_reads.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cause(input logic [CAUSE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_cause = value;
		@(posedge clk);
	endtask

	initial begin
		logic [CAUSE_W-1:0] cause_plan [5];
		logic [IDX_W-1:0] idx;
		int sent;
		int pick;
		int quiet_start;
		bit paused;
		foreach (model_csr[i])
			model_csr[i] = '0;
		model_count = '0;
		model_cycle = '0;
		model_cause = CAUSE_RESET;
		cause_plan = '{5'd31, 5'd0, CAUSE_W'($urandom), CAUSE_W'($urandom), CAUSE_RESET};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i])
			drive_item(plan[i].op, plan[i].idx, plan[i].wv, plan[i].pc, plan[i].fixed,
				plan[i].want);

		for (int phase = 0; phase < 5; phase++) begin
			drain();
			write_cause(cause_plan[phase]);
			sent = 0;
			paused = 1'b0;
			quiet_start = $urandom_range(0, PHASE_ITEMS - 40);
			while (sent < PHASE_ITEMS) begin
				quiet = (sent >= quiet_start) && (sent < quiet_start + 40);
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					// trap, look around in the handler, return
					drive_item(OP_SCALL, IDX_W'($urandom), rand_word(), rand_word(), 1'b0, '0);
					drive_item(OP_RS, IDX_W'(STATUS_INDEX), '0, '0, 1'b0, '0);
					drive_item(OP_RS, IDX_W'(CAUSE_WORD), '0, '0, 1'b0, '0);
					drive_item(OP_RW, IDX_W'(EPC_WORD), rand_word(), '0, 1'b0, '0);
					if ($urandom_range(0, 3) == 0)
						drive_item(OP_SCALL, '0, '0, rand_word(), 1'b0, '0);
					drive_item(OP_SRET, IDX_W'($urandom), rand_word(), rand_word(), 1'b0, '0);
					sent += 5;
				end else if (pick == 2) begin
					drive_item(OP_TICK, IDX_W'($urandom), rand_word(), rand_word(), 1'b0, '0);
					sent++;
				end else if (pick == 3) begin
					drive_item(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), rand_word(),
						rand_word(), 1'b0, '0);
					sent++;
				end else begin
					idx = $urandom_range(0, 1) ? hot_idx[$urandom_range(0, 7)] : IDX_W'($urandom);
					drive_item(OP_W'($urandom_range(0, 2)), idx, rand_word(), rand_word(),
						1'b0, '0);
					sent++;
				end
			end
			quiet = 1'b0;
		end

		drain();
		if (errors == 0)
			$display("csr_file_with_trap_stack_core_test: clean");
		else
			$display("csr_file_with_trap_stack_core_test: errors");
		$finish;
	end

endmodule
